// File: design/gng_pkg.sv
// ----------------------------------------------------------------------------
// gng_pkg
// Shared types, constants and helper functions for the Gaussian noise
// generator: register indexes, generator constants and the Taylor table.
// ----------------------------------------------------------------------------
package gng_pkg;

  // Fraction bits of the mean, deviation and sample formats.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int STATE_W = 31;
  localparam int MEAN_W  = 24;
  localparam int STD_W   = 23;
  localparam int CFG_W   = 31;
  localparam int CFG_IW  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_SEED = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MEAN = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_STD  = 2'd2;

  // Reset values of the registers.
  localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;
  localparam logic [STD_W-1:0]   STD_RESET  = STD_W'(64'd1 << FRAC_BITS);

  // Generator and transform constants.
  localparam logic [14:0] LCG_MUL   = 15'd16807;
  localparam logic [30:0] LCG_MOD   = 31'h7FFFFFFF;
  localparam logic [28:0] LN2X2_Q28 = 29'd372130559;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic [STATE_W-1:0] state_t;

  // The two uniforms of one draw.
  typedef struct packed {
    state_t u1;
    state_t u2;
  } pair_t;

  // One Park-Miller step: x * 16807 mod (2^31 - 1).
  function automatic state_t lcg_next(state_t x);
    logic [45:0] p;
    logic [31:0] r;
    p = 46'(x) * 46'(LCG_MUL);
    r = {1'b0, p[30:0]} + {17'b0, p[45:31]};
    if (r >= {1'b0, LCG_MOD}) begin
      r = r - {1'b0, LCG_MOD};
    end
    return r[30:0];
  endfunction

  // Denominators of the nested cosine and sine Taylor forms.
  function automatic logic [7:0] taylor_den(logic sin_sel, logic [2:0] k);
    logic [7:0] d;
    case ({sin_sel, k})
      4'b0000: d = 8'd132;
      4'b0001: d = 8'd90;
      4'b0010: d = 8'd56;
      4'b0011: d = 8'd30;
      4'b0100: d = 8'd12;
      4'b0101: d = 8'd2;
      4'b1000: d = 8'd156;
      4'b1001: d = 8'd110;
      4'b1010: d = 8'd72;
      4'b1011: d = 8'd42;
      4'b1100: d = 8'd20;
      4'b1101: d = 8'd6;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// File: design/gng_ifs.sv
// ----------------------------------------------------------------------------
// gng_ifs
// Valid/ready channels of the noise generator: the draw requests and the
// resulting samples.
// ----------------------------------------------------------------------------
interface gng_draw_if;
  logic valid;
  logic ready;
  logic draw;
  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

interface gng_sample_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample;
  logic [30:0] gen_state_out;
  modport source (output valid, output sample, output gen_state_out, input ready);
  modport sink (input valid, input sample, input gen_state_out, output ready);
endinterface

// File: design/gng_front.sv
// ----------------------------------------------------------------------------
// gng_front
// Accepts draw items, drops empty ones, steps the generator twice for each
// real draw and pushes the two uniforms into the queue.
// ----------------------------------------------------------------------------
module gng_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_draw,
  output logic            in_ready,
  input  logic            seed_load,
  input  gng_pkg::state_t seed_val,
  input  logic            fifo_full,
  output logic            push,
  output gng_pkg::pair_t  push_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_U1   = 2'd1;
  localparam logic [1:0] F_U2   = 2'd2;

  logic [1:0]      st_r, st_nxt;
  gng_pkg::state_t state_r, state_nxt;
  gng_pkg::state_t u1_r, u1_nxt;
  gng_pkg::state_t u2;

  assign in_ready = (st_r == F_IDLE) && !fifo_full;
  assign u2       = gng_pkg::lcg_next(u1_r);

  // Two generator steps, then a push; in idle a seed write loads the state.
  always_comb begin
    st_nxt    = st_r;
    state_nxt = state_r;
    u1_nxt    = u1_r;
    push      = 1'b0;
    push_data = '{u1: u1_r, u2: u2};
    case (st_r)
      F_IDLE: begin
        if (in_valid && in_ready && in_draw) begin
          st_nxt = F_U1;
        end
        if (seed_load) begin
          if (seed_val == '0 || seed_val == gng_pkg::LCG_MOD) begin
            state_nxt = gng_pkg::SEED_RESET;
          end else begin
            state_nxt = seed_val;
          end
        end
      end
      F_U1: begin
        u1_nxt = gng_pkg::lcg_next(state_r);
        st_nxt = F_U2;
      end
      F_U2: begin
        state_nxt = u2;
        push      = 1'b1;
        st_nxt    = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      state_r <= gng_pkg::SEED_RESET;
    end else begin
      st_r    <= st_nxt;
      state_r <= state_nxt;
    end
    u1_r <= u1_nxt;
  end

endmodule

// File: design/gng_fifo.sv
// ----------------------------------------------------------------------------
// gng_fifo
// Short queue of uniform pairs between the front and the back.
// ----------------------------------------------------------------------------
module gng_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gng_pkg::pair_t push_data,
  input  logic           pop,
  output gng_pkg::pair_t pop_data,
  output logic           full,
  output logic           empty
);

  gng_pkg::pair_t               mem_r [gng_pkg::FIFO_DEPTH];
  logic [gng_pkg::FIFO_AW-1:0]  wp_r, rp_r;
  logic [gng_pkg::FIFO_AW:0]    cnt_r;

  assign full     = (cnt_r == (gng_pkg::FIFO_AW+1)'(gng_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// File: design/gng_div.sv
// ----------------------------------------------------------------------------
// gng_div
// Divider for the small constant denominators of the Taylor forms: the
// quotient comes from a pipelined reciprocal multiplication.
// ----------------------------------------------------------------------------
module gng_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [30:0] quotient
);

  logic        v1_r;
  logic        v2_r;
  logic        done_r;
  logic [29:0] x_r;
  logic [30:0] rcp_r;
  logic [3:0]  sh_r;
  logic [60:0] prod_r;
  logic [30:0] quo_r;
  logic [30:0] rcp;
  logic [3:0]  lg;
  logic [30:0] shifted;

  // Reciprocal ceil(2^(30+l) / d) and l = ceil(log2 d) of each denominator.
  // With a dividend below 2^30 the truncated product equals floor(x / d).
  always_comb begin
    case (divisor)
      8'd2: begin
        rcp = 31'd1073741824;
        lg  = 4'd1;
      end
      8'd6: begin
        rcp = 31'd1431655766;
        lg  = 4'd3;
      end
      8'd12: begin
        rcp = 31'd1431655766;
        lg  = 4'd4;
      end
      8'd20: begin
        rcp = 31'd1717986919;
        lg  = 4'd5;
      end
      8'd30: begin
        rcp = 31'd1145324613;
        lg  = 4'd5;
      end
      8'd42: begin
        rcp = 31'd1636178018;
        lg  = 4'd6;
      end
      8'd56: begin
        rcp = 31'd1227133514;
        lg  = 4'd6;
      end
      8'd72: begin
        rcp = 31'd1908874354;
        lg  = 4'd7;
      end
      8'd90: begin
        rcp = 31'd1527099484;
        lg  = 4'd7;
      end
      8'd110: begin
        rcp = 31'd1249445032;
        lg  = 4'd7;
      end
      8'd132: begin
        rcp = 31'd2082408386;
        lg  = 4'd8;
      end
      8'd156: begin
        rcp = 31'd1762037866;
        lg  = 4'd8;
      end
      default: begin
        rcp = 31'd1073741824;
        lg  = 4'd0;
      end
    endcase
  end

  assign shifted  = 31'(prod_r >> (6'd30 + {2'b0, sh_r}));
  assign done     = done_r;
  assign quotient = quo_r;

  // Stage flags: operands, product, quotient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Operand, product and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      rcp_r <= rcp;
      sh_r  <= lg;
    end
    if (v1_r) begin
      prod_r <= 61'(x_r) * 61'(rcp_r);
    end
    if (v2_r) begin
      quo_r <= shifted;
    end
  end

endmodule

// File: design/gng_back.sv
// ----------------------------------------------------------------------------
// gng_back
// Box-Muller sequencer: serial log and square root, cosine and sine by nested
// Taylor forms through a shared divider, scaling, mean and saturation.
// ----------------------------------------------------------------------------
module gng_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fifo_empty,
  input  gng_pkg::pair_t              fifo_data,
  output logic                        pop,
  input  logic [gng_pkg::MEAN_W-1:0]  mean_val,
  input  logic [gng_pkg::STD_W-1:0]   std_val,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [23:0]                 out_sample,
  output logic [30:0]                 out_state
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_NORM = 4'd1;
  localparam logic [3:0] B_LOG  = 4'd2;
  localparam logic [3:0] B_MULA = 4'd3;
  localparam logic [3:0] B_MULB = 4'd4;
  localparam logic [3:0] B_SQRT = 4'd5;
  localparam logic [3:0] B_TH   = 4'd6;
  localparam logic [3:0] B_Z    = 4'd7;
  localparam logic [3:0] B_DMUL = 4'd8;
  localparam logic [3:0] B_DIV  = 4'd9;
  localparam logic [3:0] B_SMUL = 4'd10;
  localparam logic [3:0] B_MAG  = 4'd11;
  localparam logic [3:0] B_Y    = 4'd12;
  localparam logic [3:0] B_DONE = 4'd13;

  logic [3:0]  st_r;
  logic [30:0] m_r;
  logic [4:0]  sh_r;
  logic [29:0] f_r;
  logic [4:0]  cnt_r;
  logic [30:0] u2_r;
  logic [46:0] p_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [29:0] th_r;
  logic [29:0] z_r;
  logic [30:0] acc_r;
  logic [30:0] cv_r;
  logic [2:0]  k_r;
  logic        sin_r;
  logic [30:0] cmag_r;
  logic [32:0] mag_r;
  logic [27:0] y_r;
  logic        ov_r;
  logic [23:0] os_r;
  logic [30:0] ost_r;

  // Log step: square and renormalize.
  logic [61:0] sqm;
  logic [31:0] mm;
  assign sqm = 62'(m_r) * 62'(m_r);
  assign mm  = sqm[61:30];

  // Base-two log scaled by 2 ln 2, in two partial products.
  logic [34:0] l2;
  logic [45:0] hp;
  logic [63:0] tsum;
  assign l2   = {5'(sh_r + 5'd1), 30'b0} - {5'b0, f_r};
  assign hp   = 46'(l2[34:18]) * 46'(gng_pkg::LN2X2_Q28);
  assign tsum = {hp, 18'b0} + {17'b0, p_r};

  // Square root step.
  logic [5:0]  sqsh;
  logic [63:0] bitv;
  logic [63:0] strial;
  assign sqsh   = 6'd62 - {cnt_r, 1'b0};
  assign bitv   = 64'd1 << sqsh;
  assign strial = res_r + bitv;

  // Phase reduction to [0, pi/4].
  logic [1:0]  quad;
  logic [28:0] rph;
  logic        swap;
  logic [28:0] hph;
  logic [60:0] thp;
  logic [59:0] zp;
  assign quad = u2_r[30:29];
  assign rph  = u2_r[28:0];
  assign swap = rph > 29'h10000000;
  assign hph  = swap ? 29'(30'h20000000 - {1'b0, rph}) : rph;
  assign thp  = 61'(hph) * 61'(gng_pkg::PI_Q30);
  assign zp   = 60'(th_r) * 60'(th_r);

  // Taylor step product, sine product and output products.
  // The Taylor product stays below 2^60 since z and the term are at most 1.0.
  logic [59:0] ap;
  logic [60:0] sp;
  logic [30:0] sv;
  logic [62:0] mp;
  logic [55:0] yp;
  logic [30:0] div_q;
  logic        div_done;
  logic        div_start;
  logic [30:0] acc_n;
  assign ap    = 60'(z_r) * 60'(acc_r);
  assign sp    = 61'(th_r) * 61'(acc_r);
  assign sv    = sp[60:30];
  assign mp    = 63'(res_r[31:0]) * 63'(cmag_r);
  assign yp    = 56'(mag_r) * 56'(std_val) + 56'(64'd1 << 27);
  assign acc_n = gng_pkg::ONE_Q30 - div_q;
  assign div_start = (st_r == B_DMUL);

  gng_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ap[59:30]),
    .divisor  (gng_pkg::taylor_den(sin_r, k_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sign, mean and saturation.
  logic        neg;
  logic [29:0] mean_ext;
  logic [29:0] ssum;
  logic [23:0] ssat;
  assign neg      = (quad == 2'd1) || (quad == 2'd2);
  assign mean_ext = {{6{mean_val[23]}}, mean_val};
  assign ssum     = neg ? (mean_ext - {2'b0, y_r}) : (mean_ext + {2'b0, y_r});
  always_comb begin
    if (!ssum[29] && (ssum[28:23] != 6'd0)) begin
      ssat = 24'h7FFFFF;
    end else if (ssum[29] && (ssum[28:23] != 6'h3F)) begin
      ssat = 24'h800000;
    end else begin
      ssat = ssum[23:0];
    end
  end

  assign pop        = (st_r == B_IDLE) && !fifo_empty;
  assign out_valid  = ov_r;
  assign out_sample = os_r;
  assign out_state  = ost_r;

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && (st_r != B_DONE)) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: if (!fifo_empty) st_r <= B_NORM;
        B_NORM: if (m_r[30]) st_r <= B_LOG;
        B_LOG:  if (cnt_r == 5'd29) st_r <= B_MULA;
        B_MULA: st_r <= B_MULB;
        B_MULB: st_r <= B_SQRT;
        B_SQRT: if (cnt_r == 5'd31) st_r <= B_TH;
        B_TH:   st_r <= B_Z;
        B_Z:    st_r <= B_DMUL;
        B_DMUL: st_r <= B_DIV;
        B_DIV: begin
          if (div_done) begin
            st_r <= (k_r == 3'd5 && sin_r) ? B_SMUL : B_DMUL;
          end
        end
        B_SMUL: st_r <= B_MAG;
        B_MAG:  st_r <= B_Y;
        B_Y:    st_r <= B_DONE;
        B_DONE: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        m_r  <= fifo_data.u1;
        u2_r <= fifo_data.u2;
        sh_r <= '0;
        cnt_r <= '0;
      end
      B_NORM: begin
        if (!m_r[30]) begin
          m_r  <= {m_r[29:0], 1'b0};
          sh_r <= sh_r + 1'b1;
        end
      end
      B_LOG: begin
        cnt_r <= cnt_r + 1'b1;
        if (mm[31]) begin
          m_r <= mm[31:1];
          f_r <= {f_r[28:0], 1'b1};
        end else begin
          m_r <= mm[30:0];
          f_r <= {f_r[28:0], 1'b0};
        end
      end
      B_MULA: p_r <= 47'(l2[17:0]) * 47'(gng_pkg::LN2X2_Q28);
      B_MULB: begin
        v_r   <= {2'b0, tsum[63:28], 26'b0};
        res_r <= '0;
        cnt_r <= '0;
      end
      B_SQRT: begin
        cnt_r <= cnt_r + 1'b1;
        if (v_r >= strial) begin
          v_r   <= v_r - strial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      B_TH: th_r <= thp[59:30];
      B_Z: begin
        z_r   <= zp[59:30];
        acc_r <= gng_pkg::ONE_Q30;
        k_r   <= '0;
        sin_r <= 1'b0;
      end
      B_DIV: begin
        if (div_done) begin
          if (k_r == 3'd5) begin
            if (!sin_r) begin
              cv_r  <= acc_n;
              acc_r <= gng_pkg::ONE_Q30;
              k_r   <= '0;
              sin_r <= 1'b1;
            end else begin
              acc_r <= acc_n;
            end
          end else begin
            acc_r <= acc_n;
            k_r   <= k_r + 1'b1;
          end
        end
      end
      B_SMUL: begin
        if (quad == 2'd0 || quad == 2'd2) begin
          cmag_r <= swap ? sv : cv_r;
        end else begin
          cmag_r <= swap ? cv_r : sv;
        end
      end
      B_MAG: mag_r <= mp[62:30];
      B_Y:   y_r <= yp[55:28];
      B_DONE: begin
        if (!ov_r || out_ready) begin
          os_r  <= ssat;
          ost_r <= u2_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/gaussian_noise_generator_core.sv
// Flow: an accepted draw is queued after the front's two generator steps; the back then
// normalizes, takes the log and the square root and runs twelve divisions (reciprocal
// multiply) for the cosine and sine before it offers the sample. The back takes a new
// pair only when idle, the front takes a new draw only when idle and the queue is not
// full, and up to four draws queue between the parts.
// Reset (rst_n, synchronous, low): state 1, mean 0, deviation 1.0, nothing pending.
// ----------------------------------------------------------------------------
// gaussian_noise_generator_core
// Top level: configuration registers, draw front, uniform queue and the
// Box-Muller back end.
// ----------------------------------------------------------------------------
module gaussian_noise_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  gng_draw_if.sink                      in_if,
  gng_sample_if.source                  out_if,
  input  logic                          cfg_we,
  input  logic [gng_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [gng_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [gng_pkg::MEAN_W-1:0] mean_r;
  logic [gng_pkg::STD_W-1:0]  std_r;
  logic                       seed_load;
  logic                       push, pop, full, empty;
  gng_pkg::pair_t             push_data, pop_data;

  assign seed_load = cfg_we && (cfg_index == gng_pkg::CFG_SEED);

  // Mean and deviation registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= gng_pkg::STD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gng_pkg::CFG_MEAN) begin
        mean_r <= cfg_wdata[gng_pkg::MEAN_W-1:0];
      end
      if (cfg_index == gng_pkg::CFG_STD) begin
        std_r <= cfg_wdata[gng_pkg::STD_W-1:0];
      end
    end
  end

  gng_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_draw   (in_if.draw),
    .in_ready  (in_if.ready),
    .seed_load (seed_load),
    .seed_val  (cfg_wdata),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  gng_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  gng_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (empty),
    .fifo_data  (pop_data),
    .pop        (pop),
    .mean_val   (mean_r),
    .std_val    (std_r),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_sample (out_if.sample),
    .out_state  (out_if.gen_state_out)
  );

endmodule

// File: design/gng_checker.sv
// ----------------------------------------------------------------------------
// gng_checker
// Port-level checks of the noise generator, bound to the top level.
// ----------------------------------------------------------------------------
module gng_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample,
  input logic [30:0] out_state
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_state))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // The generator never reaches its stuck values.
  a_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_state != 31'd0) && (out_state != 31'h7FFFFFFF))
    else $error("generator state out of range");

endmodule

bind gaussian_noise_generator_core gng_checker u_gng_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_sample (out_if.sample),
  .out_state  (out_if.gen_state_out)
);
